FILE: design/rcbp_pkg.sv
// Shared types and constants of the Rice code bit packer.
package rcbp_pkg;

	localparam int VALUE_BITS_DEF = 16;
	localparam int LOW_BITS_MAX = 15;

	localparam logic [3:0] RICE_K_MIN = 4'd8;
	localparam logic [3:0] RICE_K_RESET = 4'd12;
	localparam logic [3:0] RICE_K_TOP = 4'd15;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [15:0] value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} out_item_t;

	// One code bit handed from the serializer to the packer.
	typedef struct packed {
		logic flush;
		logic code_bit;
		logic last;
	} beat_t;

endpackage

FILE: design/rcbp_serializer.sv
// Serializer that turns one item into its Rice code word or a flush beat, one bit per cycle while beat_ready is high.
module rcbp_serializer #(
	parameter int VALUE_BITS = rcbp_pkg::VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  rcbp_pkg::in_item_t item,
	input  logic [3:0]         rice_k,
	output logic               beat_valid,
	input  logic               beat_ready,
	output rcbp_pkg::beat_t    beat
);

	localparam int QW = VALUE_BITS - 7;
	localparam int LW = rcbp_pkg::LOW_BITS_MAX;

	localparam logic [1:0] PH_UNARY = 2'd0;
	localparam logic [1:0] PH_STOP = 2'd1;
	localparam logic [1:0] PH_LOW = 2'd2;
	localparam logic [1:0] PH_FLUSH = 2'd3;

	logic          busy_q;
	logic [1:0]    phase_q;
	logic [QW-1:0] qcnt_q;
	logic [LW-1:0] low_q;
	logic [3:0]    lcnt_q;

	logic [3:0]    k_eff;
	logic [15:0]   val_m;
	logic [15:0]   quot;
	logic [15:0]   low_al;
	logic          accept;
	logic          take;

	assign k_eff = (rice_k < rcbp_pkg::RICE_K_MIN) ? rcbp_pkg::RICE_K_MIN : rice_k;
	assign val_m = 16'(item.value[VALUE_BITS-1:0]);
	assign quot = val_m >> k_eff;
	// Left-align the k low bits so the first one sits in the top bit.
	assign low_al = val_m << (rcbp_pkg::RICE_K_TOP - k_eff);

	assign item_stall = busy_q;
	assign accept = item_valid && !busy_q;
	assign beat_valid = busy_q;
	assign take = busy_q && beat_ready;

	always_comb begin
		beat.flush = 1'b0;
		beat.code_bit = 1'b0;
		beat.last = 1'b0;
		case (phase_q)
			PH_UNARY: begin
				beat.code_bit = 1'b0;
			end
			PH_STOP: begin
				beat.code_bit = 1'b1;
			end
			PH_LOW: begin
				beat.code_bit = low_q[LW-1];
				beat.last = (lcnt_q == 4'd1);
			end
			PH_FLUSH: begin
				beat.flush = 1'b1;
				beat.last = 1'b1;
			end
			default: begin
				beat.code_bit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= PH_UNARY;
			qcnt_q <= '0;
			low_q <= '0;
			lcnt_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			qcnt_q <= quot[QW-1:0];
			low_q <= low_al[LW-1:0];
			lcnt_q <= k_eff;
			if (item.cmd == rcbp_pkg::CMD_FLUSH) begin
				phase_q <= PH_FLUSH;
			end else if (quot == 16'd0) begin
				phase_q <= PH_STOP;
			end else begin
				phase_q <= PH_UNARY;
			end
		end else if (take) begin
			case (phase_q)
				PH_UNARY: begin
					qcnt_q <= qcnt_q - 1'b1;
					if (qcnt_q == QW'(1)) begin
						phase_q <= PH_STOP;
					end
				end
				PH_STOP: begin
					phase_q <= PH_LOW;
				end
				PH_LOW: begin
					low_q <= {low_q[LW-2:0], 1'b0};
					lcnt_q <= lcnt_q - 1'b1;
					if (lcnt_q == 4'd1) begin
						busy_q <= 1'b0;
					end
				end
				PH_FLUSH: begin
					busy_q <= 1'b0;
				end
				default: begin
					busy_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

FILE: design/rcbp_packer.sv
// Byte packer: shifts code bits into bytes and marks the last byte of each item.
module rcbp_packer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                beat_valid,
	output logic                beat_ready,
	input  rcbp_pkg::beat_t     beat,
	output logic                res_valid,
	input  logic                res_stall,
	output rcbp_pkg::out_item_t res
);

	logic [6:0]          pend_q;
	logic [2:0]          cnt_q;
	logic [7:0]          hold_q;
	logic                hold_v_q;
	logic                hold_fin_q;
	rcbp_pkg::out_item_t res_q;
	logic                res_v_q;

	logic       draining;
	logic       comp;
	logic [2:0] pad_sh;
	logic [7:0] byte_b;
	logic       need_out;
	logic       out_free;
	logic       take;
	logic       load_out;

	// The newest finished byte waits in the hold register until it is known
	// whether it is the last byte of its item.
	assign draining = hold_v_q && hold_fin_q;
	assign comp = beat.flush ? (cnt_q != 3'd0) : (cnt_q == 3'd7);
	assign pad_sh = 3'd0 - cnt_q;
	assign byte_b = beat.flush ? ({1'b0, pend_q} << pad_sh) : {pend_q, beat.code_bit};
	assign need_out = hold_v_q && (comp || beat.last);
	assign out_free = !res_v_q || !res_stall;
	assign beat_ready = !draining && (!need_out || out_free);
	assign take = beat_valid && beat_ready;
	assign load_out = (draining && out_free) || (take && need_out);

	assign res_valid = res_v_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q <= '0;
			hold_v_q <= 1'b0;
			hold_fin_q <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (load_out) begin
				res_v_q <= 1'b1;
			end else if (res_v_q && !res_stall) begin
				res_v_q <= 1'b0;
			end
			if (draining) begin
				if (out_free) begin
					hold_v_q <= 1'b0;
					hold_fin_q <= 1'b0;
				end
			end else if (take) begin
				if (beat.flush) begin
					cnt_q <= 3'd0;
				end else begin
					pend_q <= {pend_q[5:0], beat.code_bit};
					cnt_q <= cnt_q + 1'b1;
				end
				if (comp) begin
					hold_v_q <= 1'b1;
					hold_fin_q <= beat.last;
				end else if (need_out) begin
					hold_v_q <= 1'b0;
					hold_fin_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (draining) begin
			if (out_free) begin
				res_q.out_byte <= hold_q;
				res_q.last_byte <= 1'b1;
			end
		end else if (take) begin
			if (need_out) begin
				res_q.out_byte <= hold_q;
				res_q.last_byte <= beat.last && !comp;
			end
			if (comp) begin
				hold_q <= byte_b;
			end
		end
	end

endmodule

FILE: design/rice_code_bit_packer.sv
// Golomb-Rice encoder with an MSB-first byte packer.
//
// Items arrive on the item channel (valid/stall): cmd encodes value or
// flushes the pending bits. Packed bytes leave on the res channel
// (valid/stall), first code bit in the MSB; last_byte marks the final byte
// of each item, and an item that finishes no byte gives no beat at all.
// The rice_k register is written over the cfg channel (valid/ready) while
// the block is idle, a rule on the user that the block does not enforce;
// values below 8 act as 8. One item is taken at a time. An encode item
// gives q zero bits, a one stop bit and k low bits (q = value >> k), one
// code bit per cycle while the packer is ready. A flush item pads any
// pending bits with zeros to a byte. Each finished byte passes through
// the hold register to the output register. The output register
// decouples the receiver: while res_stall is high the byte on res holds,
// and the packer stops only when it must hand over a further byte. Reset
// clears the pending bits, sets rice_k to 12 and leaves both channels empty.
module rice_code_bit_packer #(
	parameter int VALUE_BITS = rcbp_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  rcbp_pkg::in_item_t  item,
	output logic                res_valid,
	input  logic                res_stall,
	output rcbp_pkg::out_item_t res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [3:0]          cfg_data
);

	logic            beat_valid;
	logic            beat_ready;
	rcbp_pkg::beat_t beat;
	logic [3:0]      rice_k_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rice_k_q <= rcbp_pkg::RICE_K_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rice_k_q <= cfg_data;
		end
	end

	rcbp_serializer #(
		.VALUE_BITS(VALUE_BITS)
	) u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.rice_k    (rice_k_q),
		.beat_valid(beat_valid),
		.beat_ready(beat_ready),
		.beat      (beat)
	);

	rcbp_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_valid(beat_valid),
		.beat_ready(beat_ready),
		.beat      (beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
